// ----- design/assert_macros.svh -----
// Assertion macros shared by the RTL of the sorted ready queue.
// Depends on nothing; included by the files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A condition that holds at every clock edge out of reset.
`define SQ_ASSERT_ALWAYS(label, clk, rst_n, cond, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);

// A trigger that forces a consequence at the next clock edge.
`define SQ_ASSERT_NEXT(label, clk, rst_n, trig, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/sq_pkg.sv -----
// Package of the sorted ready queue: depth, record type, codes and cell controls.
// Depends on nothing; imported by sq_cell and sorted_ready_queue.
package sq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  localparam logic       KIND_PUSH = 1'b0;
  localparam logic       KIND_POP  = 1'b1;

  localparam logic [1:0] STATUS_DONE  = 2'd0;
  localparam logic [1:0] STATUS_EMPTY = 2'd1;
  localparam logic [1:0] STATUS_FULL  = 2'd2;

  localparam logic [1:0] MODE_FCFS  = 2'd0;
  localparam logic [1:0] MODE_RR    = 2'd1;
  localparam logic [1:0] MODE_SJF   = 2'd2;
  localparam logic [1:0] MODE_PRIO  = 2'd3;

  typedef struct packed {
    logic [15:0] id;
    logic [15:0] arrival;
    logic [15:0] burst;
    logic [7:0]  prio;
    logic [31:0] addr;
  } rec_t;

  typedef struct packed {
    logic       compare;
    logic       insert;
    logic       pop;
    logic [1:0] mode;
  } cell_ctrl_t;

endpackage

// ----- design/sq_cell.sv -----
// One slot of the sorted queue: holds a record, compares it with a new request
// and shifts toward head or tail. Depends on sq_pkg.
module sq_cell
  import sq_pkg::*;
(
  input  logic       clk,
  input  cell_ctrl_t ctrl,
  input  rec_t       cmp_rec,
  input  rec_t       ins_rec,
  input  rec_t       left_rec,
  input  rec_t       right_rec,
  input  logic       occupied,
  input  logic       at_tail,
  input  logic       taken_in,
  output logic       taken_out,
  output rec_t       rec
);

  rec_t rec_r;
  rec_t rec_nxt;
  logic beats_r;
  logic beats_nxt;
  logic beats_now;
  logic ins;

  // The new record belongs ahead of the stored one.
  always_comb begin
    if (cmp_rec.arrival != rec_r.arrival) begin
      beats_now = cmp_rec.arrival < rec_r.arrival;
    end else if (ctrl.mode == MODE_SJF && cmp_rec.burst != rec_r.burst) begin
      beats_now = cmp_rec.burst < rec_r.burst;
    end else if (ctrl.mode == MODE_PRIO && cmp_rec.prio != rec_r.prio) begin
      beats_now = cmp_rec.prio > rec_r.prio;
    end else begin
      beats_now = cmp_rec.id < rec_r.id;
    end
  end

  assign beats_nxt = ctrl.compare ? beats_now : beats_r;
  assign ins       = !taken_in && ((beats_r && occupied) || at_tail);
  assign taken_out = taken_in || ins;

  always_comb begin
    rec_nxt = rec_r;
    if (ctrl.pop) begin
      rec_nxt = right_rec;
    end else if (ctrl.insert) begin
      if (taken_in) begin
        rec_nxt = left_rec;
      end else if (ins) begin
        rec_nxt = ins_rec;
      end
    end
  end

  always_ff @(posedge clk) begin
    rec_r   <= rec_nxt;
    beats_r <= beats_nxt;
  end

  assign rec = rec_r;

endmodule

// ----- design/sorted_ready_queue.sv -----
// Top level of the sorted ready queue: request register, chain of slots,
// control and result register. Depends on sq_pkg, sq_cell and assert_macros.svh.
//
// Usage. A request enters on the in_ channel (valid/ready). A push carries a
// process record that is inserted in sorted order: arrival time ascending, ties
// broken as selected by order_mode, then by process id ascending. A pop removes
// the head record. Every request returns exactly one result on the out_ channel
// with a status, the popped record (zero otherwise) and the count afterwards.
// order_mode is written on the cfg_ channel, which is always ready.
// Timing: every slot compares its record with the request at the edge that
// accepts it; in the execute state the first winning slot along the chain is
// resolved, the records shift and the result is registered, and no new request
// is taken until that request has executed.
// A finished result waits in the output register while the next request is
// accepted; only the shift cycle of that request stalls until out_ready.
// Reset clears the count, the mode and the handshake state; slot contents are
// not cleared, since only slots below the count are ever read.
module sorted_ready_queue
  import sq_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [1:0]        cfg_order_mode,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_kind,
  input  logic [15:0]       in_proc_id,
  input  logic [15:0]       in_arrival_time,
  input  logic [15:0]       in_burst_time,
  input  logic [7:0]        in_prio_level,
  input  logic [31:0]       in_addr_word,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [1:0]        out_status,
  output logic [15:0]       out_id,
  output logic [15:0]       out_burst,
  output logic [7:0]        out_prio,
  output logic [31:0]       out_addr,
  output logic [CNT_W-1:0]  out_entry_count
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic             state_r, state_nxt;
  logic [1:0]       mode_r, mode_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [1:0]       status_r, status_nxt;
  rec_t             head_r, head_nxt;
  logic             kind_r, kind_nxt;
  rec_t             req_r, req_nxt;
  rec_t             in_rec;
  logic             in_fire;
  logic             exec_go;
  logic             full;
  logic             empty;
  cell_ctrl_t       ctrl;
  rec_t             cell_rec [QUEUE_DEPTH];
  logic [QUEUE_DEPTH:0] taken;

  assign cfg_ready = 1'b1;
  assign in_ready  = (state_r == ST_IDLE);
  assign in_fire   = in_valid && in_ready;
  assign exec_go   = (state_r == ST_EXEC) && (!out_valid_r || out_ready);
  assign full      = (count_r == CNT_W'(QUEUE_DEPTH));
  assign empty     = (count_r == '0);

  assign in_rec.id      = in_proc_id;
  assign in_rec.arrival = in_arrival_time;
  assign in_rec.burst   = in_burst_time;
  assign in_rec.prio    = in_prio_level;
  assign in_rec.addr    = in_addr_word;

  assign ctrl.compare = in_fire;
  assign ctrl.insert  = exec_go && (kind_r == KIND_PUSH) && !full;
  assign ctrl.pop     = exec_go && (kind_r == KIND_POP) && !empty;
  assign ctrl.mode    = mode_r;

  assign taken[0] = 1'b0;

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    sq_cell u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .cmp_rec   (in_rec),
      .ins_rec   (req_r),
      .left_rec  (cell_rec[(i == 0) ? 0 : i - 1]),
      .right_rec (cell_rec[(i == QUEUE_DEPTH - 1) ? i : i + 1]),
      .occupied  (count_r > CNT_W'(i)),
      .at_tail   (count_r == CNT_W'(i)),
      .taken_in  (taken[i]),
      .taken_out (taken[i+1]),
      .rec       (cell_rec[i])
    );
  end

  always_comb begin
    state_nxt     = state_r;
    mode_nxt      = mode_r;
    count_nxt     = count_r;
    out_valid_nxt = out_valid_r;
    status_nxt    = status_r;
    head_nxt      = head_r;
    kind_nxt      = kind_r;
    req_nxt       = req_r;
    if (cfg_valid) begin
      mode_nxt = cfg_order_mode;
    end
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (in_fire) begin
      state_nxt = ST_EXEC;
      kind_nxt  = in_kind;
      req_nxt   = in_rec;
    end
    if (exec_go) begin
      state_nxt     = ST_IDLE;
      out_valid_nxt = 1'b1;
      status_nxt    = STATUS_DONE;
      head_nxt      = '0;
      if (kind_r == KIND_PUSH) begin
        if (full) begin
          status_nxt = STATUS_FULL;
        end else begin
          count_nxt = count_r + 1'b1;
        end
      end else begin
        if (empty) begin
          status_nxt = STATUS_EMPTY;
        end else begin
          head_nxt  = cell_rec[0];
          count_nxt = count_r - 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      mode_r      <= MODE_FCFS;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      mode_r      <= mode_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    status_r <= status_nxt;
    head_r   <= head_nxt;
    kind_r   <= kind_nxt;
    req_r    <= req_nxt;
  end

  logic [CNT_W-1:0] result_count_r;
  always_ff @(posedge clk) begin
    if (exec_go) begin
      result_count_r <= count_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_status      = status_r;
  assign out_id          = head_r.id;
  assign out_burst       = head_r.burst;
  assign out_prio        = head_r.prio;
  assign out_addr        = head_r.addr;
  assign out_entry_count = result_count_r;

`include "assert_macros.svh"

  `SQ_ASSERT_ALWAYS(a_count_bound, clk, rst_n, count_r <= CNT_W'(QUEUE_DEPTH), "count overflow")
  `SQ_ASSERT_NEXT(a_exec_result, clk, rst_n, exec_go, out_valid_r && in_ready, "result missing")
  `SQ_ASSERT_NEXT(a_pop_count, clk, rst_n, ctrl.pop, count_r == $past(count_r) - 1'b1, "pop lost")
  `SQ_ASSERT_NEXT(a_insert_count, clk, rst_n, ctrl.insert, count_r == $past(count_r) + 1'b1, "push lost")
  `SQ_ASSERT_ALWAYS(a_insert_slot, clk, rst_n, !ctrl.insert || taken[QUEUE_DEPTH], "no slot taken")

endmodule
